>>> hdl/bgu_pkg.sv
// shared types, constants and the sigmoid table function for the gibbs unit update block
// no dependencies
package bgu_pkg;

  localparam int UNITS_DEF           = 16;
  localparam int WEIGHT_BITS_DEF     = 16;
  localparam int SIGMOID_ENTRIES_DEF = 1024;

  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int FIELD_BITS        = 21;
  localparam int PROB_BITS         = 16;
  localparam int PATTERN_BITS      = 16;
  localparam int CLIP_BITS         = 24;
  localparam int INV_T_BITS        = 16;
  localparam int VARIANT_BITS      = 3;
  localparam int CFG_INDEX_BITS    = 1;
  localparam int CFG_DATA_BITS     = 16;

  localparam logic [INV_T_BITS-1:0] INV_T_RESET = 16'd256;

  typedef enum logic [1:0] {
    MODE_WRITE_WEIGHT = 2'd0,
    MODE_WRITE_BIT    = 2'd1,
    MODE_UPDATE       = 2'd2,
    MODE_NOP          = 2'd3
  } mode_t;

  typedef enum logic [VARIANT_BITS-1:0] {
    VAR_BIAS_ROW      = 3'd0,
    VAR_DIAG_BIAS     = 3'd1,
    VAR_OFF_DIAG      = 3'd2,
    VAR_FULL          = 3'd3,
    VAR_DIAG_BIAS_ALT = 3'd4
  } variant_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIELD_VARIANT = 1'b0,
    CFG_INV_TEMP      = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SCALE,
    ST_INDEX,
    ST_LOOKUP,
    ST_DONE
  } bgu_state_t;

  typedef struct packed {
    logic idle;
    logic scan;
    logic scale;
    logic index;
    logic lookup;
    logic finish;
  } bgu_cmd_t;

  typedef struct packed {
    logic start_update;
    logic start_other;
    logic scan_last;
    logic out_free;
  } bgu_sts_t;

  // shift and subtract quotient for the table build, operands non-negative
  function automatic longint table_div(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  // sigmoid at a bin midpoint given in Q.24, result Q0.16
  function automatic logic [PROB_BITS-1:0] sigmoid_entry(input longint mid);
    longint x;
    longint u;
    longint term;
    longint sum;
    longint y;
    longint den;
    longint p;
    x = mid - (longint'(1) << 27);
    u = (x < 0 ? -x : x) << 4;
    if (u > (longint'(1) << 31)) u = longint'(1) << 31;
    term = longint'(1) << 31;
    sum  = term;
    for (int i = 1; i <= 12; i++) begin
      term = table_div((term * u) >> 31, longint'(i));
      if (i[0]) sum = sum - term;
      else      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 31)) sum = longint'(1) << 31;
    y = sum;
    for (int s = 0; s < 3; s++) begin
      y = (y * y + (longint'(1) << 30)) >> 31;
    end
    den = (longint'(1) << 31) + y;
    if (x >= 0) p = table_div((longint'(1) << 47) + (den >> 1), den);
    else        p = table_div((y << 16) + (den >> 1), den);
    if (p > 65535) p = 65535;
    return PROB_BITS'(p);
  endfunction

endpackage

>>> hdl/bgu_in_if.sv
// input word channel of the gibbs unit update block
// no dependencies
interface bgu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         unit_index;
  logic [3:0]         column_index;
  logic signed [15:0] weight_value;
  logic               bit_value;
  logic [15:0]        random_value;

  modport source (
    output valid, mode, unit_index, column_index, weight_value, bit_value, random_value,
    input  ready
  );
  modport sink (
    input  valid, mode, unit_index, column_index, weight_value, bit_value, random_value,
    output ready
  );
endinterface

>>> hdl/bgu_out_if.sv
// result word channel of the gibbs unit update block
// no dependencies
interface bgu_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         unit_out;
  logic               new_bit;
  logic [15:0]        probability;
  logic signed [20:0] local_field;
  logic [15:0]        pattern_code;

  modport source (
    output valid, unit_out, new_bit, probability, local_field, pattern_code,
    input  ready
  );
  modport sink (
    input  valid, unit_out, new_bit, probability, local_field, pattern_code,
    output ready
  );
endinterface

>>> hdl/bgu_ctrl.sv
// sequencer for the gibbs unit update block
// depends on bgu_pkg
module bgu_ctrl import bgu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bgu_sts_t sts,
  output bgu_cmd_t cmd
);

  bgu_state_t state;
  bgu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.start_update) begin
          state_next = ST_SCAN;
        end else if (sts.start_other) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.index  = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bgu_datapath.sv
// weight memory, unit pattern, field accumulator, scaling, sigmoid rom and result register
// depends on bgu_pkg, bgu_in_if, bgu_out_if
module bgu_datapath import bgu_pkg::*; #(
  parameter int UNITS           = UNITS_DEF,
  parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF,
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  bgu_in_if.sink                    item,
  bgu_out_if.source                 result,
  input  bgu_cmd_t                  cmd,
  output bgu_sts_t                  sts
);

  localparam int SW = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ? WEIGHT_BITS : WEIGHT_FIELD_BITS;
  localparam int UIDX        = $clog2(UNITS);
  localparam int STEP_BITS   = $clog2(UNITS + 1);
  localparam int ADDR_BITS   = $clog2(UNITS * UNITS);
  localparam int ACC_BITS    = SW + $clog2(UNITS) + 1;
  localparam int SAT_BITS    = ((ACC_BITS > FIELD_BITS) ? ACC_BITS : FIELD_BITS) + 1;
  localparam int SCALE_BITS  = FIELD_BITS + INV_T_BITS + 1;
  localparam int IDX_BITS    = $clog2(SIGMOID_ENTRIES);
  localparam int OFS_BITS    = CLIP_BITS + IDX_BITS + 1;

  localparam logic signed [SAT_BITS-1:0] F_MAX =
    SAT_BITS'((longint'(1) << (FIELD_BITS - 1)) - 1);
  localparam logic signed [SAT_BITS-1:0] F_MIN =
    SAT_BITS'(-(longint'(1) << (FIELD_BITS - 1)));
  localparam logic signed [SCALE_BITS-1:0] C_HI =
    SCALE_BITS'((longint'(1) << (CLIP_BITS - 1)) - 1);
  localparam logic signed [SCALE_BITS-1:0] C_LO =
    SCALE_BITS'(-(longint'(1) << (CLIP_BITS - 1)));

  // configuration
  logic [VARIANT_BITS-1:0] variant;
  logic [INV_T_BITS-1:0]   inv_temp;
  logic [VARIANT_BITS-1:0] eff_var;

  // captured item
  logic [1:0]          mode_q;
  logic [3:0]          unit_q;
  logic [3:0]          col_q;
  logic [SW-1:0]       weight_q;
  logic                bit_q;
  logic [PROB_BITS-1:0] rnd_q;
  logic                unit_ok_q;
  logic                col_ok_q;
  logic                upd_q;

  logic accept;
  logic unit_ok_in;
  logic col_ok_in;
  logic upd_in;

  // scan
  logic [STEP_BITS-1:0] step;
  logic                 in_row;
  logic [UIDX-1:0]      row;
  logic [UIDX-1:0]      col;
  logic [UIDX-1:0]      pos_scan;
  logic                 pbit;
  logic                 diag;
  logic                 inc;
  logic                 inc_q;
  logic                 rd_vld;
  logic [ADDR_BITS-1:0] raddr;
  logic [ADDR_BITS-1:0] waddr;
  logic                 mem_we;
  logic [SW-1:0]        rd_data;
  logic [SW-1:0]        weight_mem [UNITS * UNITS];

  logic signed [ACC_BITS-1:0]   acc;
  logic signed [SAT_BITS-1:0]   acc_ext;
  logic signed [FIELD_BITS-1:0] field_sat;
  logic signed [FIELD_BITS-1:0] field_q;
  logic signed [SCALE_BITS-1:0] product_q;
  logic [CLIP_BITS-1:0]         clipped;
  logic [CLIP_BITS-1:0]         offset;
  logic [OFS_BITS-1:0]          idx_prod;
  logic [IDX_BITS-1:0]          idx_q;
  logic [PROB_BITS-1:0]         prob_q;
  logic [PROB_BITS-1:0]         sig_rom [SIGMOID_ENTRIES];

  // pattern and result
  logic [UNITS-1:0] pattern;
  logic [UNITS-1:0] pattern_next;
  logic [UIDX-1:0]  pos;
  logic             set_bit;
  logic             bitv;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant  <= VAR_BIAS_ROW;
      inv_temp <= INV_T_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIELD_VARIANT: variant  <= cfg_data[VARIANT_BITS-1:0];
        CFG_INV_TEMP:      inv_temp <= cfg_data[INV_T_BITS-1:0];
      endcase
    end
  end

  assign eff_var = (variant > VAR_DIAG_BIAS_ALT) ? VAR_BIAS_ROW : variant;

  assign item.ready = cmd.idle;
  assign accept     = item.valid && cmd.idle;
  assign unit_ok_in = 32'(item.unit_index) < 32'(UNITS);
  assign col_ok_in  = 32'(item.column_index) < 32'(UNITS);
  assign upd_in     = (item.mode == MODE_UPDATE) && unit_ok_in;

  always_comb begin
    sts.start_update = accept && upd_in;
    sts.start_other  = accept && !upd_in;
    sts.scan_last    = step == STEP_BITS'(UNITS);
    sts.out_free     = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q    <= item.mode;
      unit_q    <= item.unit_index;
      col_q     <= item.column_index;
      weight_q  <= item.weight_value[SW-1:0];
      bit_q     <= item.bit_value;
      rnd_q     <= item.random_value;
      unit_ok_q <= unit_ok_in;
      col_ok_q  <= col_ok_in;
      upd_q     <= upd_in;
    end
  end

  // one weight read per cycle, the bias read comes after the row
  assign row      = UIDX'(unit_q);
  assign in_row   = step < STEP_BITS'(UNITS);
  assign col      = UIDX'(step);
  assign pos_scan = UIDX'(UNITS - 1) - col;
  assign pbit     = in_row ? pattern[pos_scan] : 1'b0;
  assign diag     = col == row;
  assign raddr    = in_row ? ADDR_BITS'(int'(row) * UNITS + int'(col)) : ADDR_BITS'(row);
  assign waddr    = ADDR_BITS'(int'(row) * UNITS + int'(col_q));
  assign mem_we   = cmd.finish && (mode_q == MODE_WRITE_WEIGHT) && unit_ok_q && col_ok_q;

  always_comb begin
    inc = 1'b0;
    if (!in_row) begin
      inc = eff_var == VAR_BIAS_ROW;
    end else begin
      unique case (eff_var)
        VAR_BIAS_ROW:                     inc = (col != '0) && pbit;
        VAR_DIAG_BIAS, VAR_DIAG_BIAS_ALT: inc = diag || pbit;
        VAR_OFF_DIAG:                     inc = !diag && pbit;
        VAR_FULL:                         inc = pbit;
        default:                          inc = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      weight_mem[waddr] <= weight_q;
    end
    rd_data <= weight_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.idle) begin
        step <= '0;
      end else if (cmd.scan) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_q <= inc;
    if (cmd.idle) begin
      acc <= '0;
    end else if (rd_vld && inc_q) begin
      acc <= acc + ACC_BITS'($signed(rd_data));
    end
  end

  // saturate, scale, clip
  assign acc_ext = SAT_BITS'(acc);

  always_comb begin
    if (acc_ext > F_MAX) begin
      field_sat = F_MAX[FIELD_BITS-1:0];
    end else if (acc_ext < F_MIN) begin
      field_sat = F_MIN[FIELD_BITS-1:0];
    end else begin
      field_sat = acc_ext[FIELD_BITS-1:0];
    end
  end

  always_comb begin
    if (product_q > C_HI) begin
      clipped = C_HI[CLIP_BITS-1:0];
    end else if (product_q < C_LO) begin
      clipped = C_LO[CLIP_BITS-1:0];
    end else begin
      clipped = product_q[CLIP_BITS-1:0];
    end
  end

  assign offset   = {~clipped[CLIP_BITS-1], clipped[CLIP_BITS-2:0]};
  assign idx_prod = OFS_BITS'(offset) * OFS_BITS'(SIGMOID_ENTRIES);

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam longint MID = ((2 * longint'(k) + 1) << 27) / SIGMOID_ENTRIES;
    localparam logic [PROB_BITS-1:0] ENTRY = sigmoid_entry(MID);
    assign sig_rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      field_q   <= field_sat;
      product_q <= SCALE_BITS'(field_sat) * SCALE_BITS'($signed({1'b0, inv_temp}));
    end
    if (cmd.index) begin
      idx_q <= idx_prod[CLIP_BITS +: IDX_BITS];
    end
    if (cmd.lookup) begin
      prob_q <= sig_rom[idx_q];
    end
  end

  // pattern update and result word
  assign pos = UIDX'(UNITS - 1) - row;

  always_comb begin
    bitv    = 1'b0;
    set_bit = 1'b0;
    unique case (mode_q)
      MODE_WRITE_BIT: begin
        bitv    = bit_q;
        set_bit = unit_ok_q;
      end
      MODE_UPDATE: begin
        bitv    = prob_q > rnd_q;
        set_bit = unit_ok_q;
      end
      MODE_WRITE_WEIGHT, MODE_NOP: begin
        set_bit = 1'b0;
      end
    endcase
    pattern_next = pattern;
    if (set_bit) begin
      pattern_next[pos] = bitv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern   <= '0;
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      pattern   <= pattern_next;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.unit_out     <= unit_q;
      result.new_bit      <= unit_ok_q ? pattern_next[pos] : 1'b0;
      result.probability  <= upd_q ? prob_q : '0;
      result.local_field  <= upd_q ? field_q : '0;
      result.pattern_code <= PATTERN_BITS'(pattern_next);
    end
  end

  assign result.valid = out_valid;

endmodule

>>> hdl/boltzmann_gibbs_unit_update.sv
// gibbs unit update: an update word runs through the scan, drain, scale, index, lookup
// and done states before the next accept, loading the result register as it leaves done;
// the field is summed one weight per cycle through the single read port of the weight
// memory, then a bias read; write words go from idle straight to done; the next word is
// taken while a result waits in its register; synchronous reset clears the unit pattern,
// the variant (0) and inverse temperature (1.0); the weight memory is not cleared
module boltzmann_gibbs_unit_update import bgu_pkg::*; #(
  parameter int UNITS           = UNITS_DEF,
  parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF,
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  bgu_in_if.sink                    item,
  bgu_out_if.source                 result
);

  bgu_cmd_t cmd;
  bgu_sts_t sts;

  bgu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  bgu_datapath #(
    .UNITS           (UNITS),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef NO_ASSERTIONS
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second word accepted while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result.valid || result.ready))
    else $error("result register overwritten before it was taken");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && sts.scan_last |=> !cmd.scan)
    else $error("weight scan ran past its last read");

  a_lookup_order: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> $past(cmd.index))
    else $error("sigmoid lookup without a fresh table index");
`endif

endmodule
